// ===== rtl/mlfc_pkg.sv =====
// ----------------------------------------------------------------------------
// mlfc_pkg
// Shared types and constants of the meter-link frame checker.
// ----------------------------------------------------------------------------
package mlfc_pkg;

	localparam logic [7:0] HEAD_BYTE        = 8'h68;
	localparam logic [7:0] END_BYTE         = 8'h16;
	localparam logic [7:0] PAYLOAD_OFFSET   = 8'h33;
	localparam logic [8:0] SECOND_HEAD_POS  = 9'd7;
	localparam logic [8:0] LENGTH_POS       = 9'd9;
	localparam logic [8:0] PAYLOAD_START    = 9'd10;
	localparam logic [2:0] IDENT_LENGTH_RST = 3'd4;

	typedef enum logic [1:0] {
		KIND_IDENT  = 2'd0,
		KIND_VALUE  = 2'd1,
		KIND_STATUS = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ST_OK              = 3'd0,
		ST_BAD_HEAD        = 3'd1,
		ST_BAD_SECOND_HEAD = 3'd2,
		ST_TRUNCATED       = 3'd3,
		ST_BAD_END         = 3'd4,
		ST_BAD_CHECKSUM    = 3'd5,
		ST_SHORT_PAYLOAD   = 3'd6
	} status_t;

	typedef enum logic [0:0] {
		PH_RECEIVING = 1'b0,
		PH_IGNORING  = 1'b1
	} phase_t;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       buffer_end;
	} item_t;

	typedef struct packed {
		logic       has;
		kind_t      kind;
		logic [7:0] payload_byte;
		logic [7:0] payload_index;
		status_t    status;
		logic       frame_done;
	} result_t;

endpackage

// ===== rtl/mlfc_if.sv =====
// ----------------------------------------------------------------------------
// mlfc_rx_if / mlfc_res_if
// Valid/ready channels for received bytes and for checker results.
// ----------------------------------------------------------------------------
interface mlfc_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	logic       buffer_end;

	modport source (output valid, output rx_byte, output buffer_end, input ready);
	modport sink   (input valid, input rx_byte, input buffer_end, output ready);
endinterface

interface mlfc_res_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] payload_byte;
	logic [7:0] payload_index;
	logic [2:0] status;
	logic       frame_done;

	modport source (output valid, output kind, output payload_byte, output payload_index,
		output status, output frame_done, input ready);
	modport sink   (input valid, input kind, input payload_byte, input payload_index,
		input status, input frame_done, output ready);
endinterface

// ===== rtl/mlfc_frame.sv =====
// ----------------------------------------------------------------------------
// mlfc_frame
// Frame state and per-byte decode: position, length, checksum, phase.
// ----------------------------------------------------------------------------
module mlfc_frame (
	input  logic              clk,
	input  logic              arst_n,
	input  mlfc_pkg::item_t   item,
	input  logic              advance,
	input  logic [2:0]        ident_length,
	output mlfc_pkg::result_t result
);

	mlfc_pkg::phase_t phase_q, phase_d;
	logic [8:0] pos_q, pos_d;
	logic [7:0] len_q, len_d;
	logic [7:0] sum_q, sum_d;
	logic       match_q, match_d;

	logic [9:0] pos_w;
	logic [9:0] chk_pos;
	logic [9:0] fin_pos;
	logic [8:0] idx;
	logic       code_valid;
	mlfc_pkg::status_t code;
	logic       payload;
	logic       take_len;
	logic       take_match;
	logic       add_sum;

	assign pos_w   = {1'b0, pos_q};
	assign chk_pos = {1'b0, mlfc_pkg::PAYLOAD_START} + {2'b00, len_q};
	assign fin_pos = chk_pos + 10'd1;
	assign idx     = pos_q - mlfc_pkg::PAYLOAD_START;

	always_comb begin
		code_valid = 1'b0;
		code       = mlfc_pkg::ST_OK;
		payload    = 1'b0;
		take_len   = 1'b0;
		take_match = 1'b0;
		if (pos_q == 9'd0) begin
			code_valid = (item.rx_byte != mlfc_pkg::HEAD_BYTE);
			code       = mlfc_pkg::ST_BAD_HEAD;
		end else if (pos_q == mlfc_pkg::SECOND_HEAD_POS) begin
			code_valid = (item.rx_byte != mlfc_pkg::HEAD_BYTE);
			code       = mlfc_pkg::ST_BAD_SECOND_HEAD;
		end else if (pos_q == mlfc_pkg::LENGTH_POS) begin
			take_len = 1'b1;
		end else if (pos_w >= {1'b0, mlfc_pkg::PAYLOAD_START} && pos_w < chk_pos) begin
			payload = 1'b1;
		end else if (pos_w == chk_pos) begin
			take_match = 1'b1;
		end else if (pos_w == fin_pos) begin
			code_valid = 1'b1;
			if (!match_q) begin
				code = mlfc_pkg::ST_BAD_CHECKSUM;
			end else if (item.rx_byte != mlfc_pkg::END_BYTE) begin
				code = mlfc_pkg::ST_BAD_END;
			end else if (len_q < {5'b00000, ident_length}) begin
				code = mlfc_pkg::ST_SHORT_PAYLOAD;
			end else begin
				code = mlfc_pkg::ST_OK;
			end
		end
		add_sum = (pos_w < chk_pos) || (pos_q <= mlfc_pkg::LENGTH_POS);
	end

	always_comb begin
		phase_d = phase_q;
		pos_d   = pos_q;
		len_d   = len_q;
		sum_d   = sum_q;
		match_d = match_q;
		unique case (phase_q)
			mlfc_pkg::PH_RECEIVING: begin
				pos_d = pos_q + 9'd1;
				if (take_len) begin
					len_d = item.rx_byte;
				end
				if (take_match) begin
					match_d = (sum_q == item.rx_byte);
				end
				if (add_sum) begin
					sum_d = sum_q + item.rx_byte;
				end
				if (code_valid && !item.buffer_end) begin
					phase_d = mlfc_pkg::PH_IGNORING;
				end
			end
			mlfc_pkg::PH_IGNORING: begin
				phase_d = mlfc_pkg::PH_IGNORING;
			end
			default: begin
				phase_d = mlfc_pkg::PH_RECEIVING;
			end
		endcase
		if (item.buffer_end) begin
			phase_d = mlfc_pkg::PH_RECEIVING;
			pos_d   = '0;
			len_d   = '0;
			sum_d   = '0;
			match_d = 1'b0;
		end
	end

	always_comb begin
		result = '0;
		unique case (phase_q)
			mlfc_pkg::PH_RECEIVING: begin
				if (code_valid || item.buffer_end) begin
					result.has        = 1'b1;
					result.kind       = mlfc_pkg::KIND_STATUS;
					result.status     = code_valid ? code : mlfc_pkg::ST_TRUNCATED;
					result.frame_done = 1'b1;
				end else if (payload) begin
					result.has           = 1'b1;
					result.kind          = (idx < {6'b000000, ident_length}) ?
						mlfc_pkg::KIND_IDENT : mlfc_pkg::KIND_VALUE;
					result.payload_byte  = item.rx_byte - mlfc_pkg::PAYLOAD_OFFSET;
					result.payload_index = idx[7:0];
				end
			end
			mlfc_pkg::PH_IGNORING: begin
				result = '0;
			end
			default: begin
				result = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= mlfc_pkg::PH_RECEIVING;
			pos_q   <= '0;
			len_q   <= '0;
			sum_q   <= '0;
			match_q <= 1'b0;
		end else if (advance) begin
			phase_q <= phase_d;
			pos_q   <= pos_d;
			len_q   <= len_d;
			sum_q   <= sum_d;
			match_q <= match_d;
		end
	end

endmodule

// ===== rtl/meter_link_frame_checker.sv =====
// ----------------------------------------------------------------------------
// meter_link_frame_checker
// Checks meter-link frames byte by byte, strips payload bytes, reports status.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake    | payload
//  rx       | in  | valid/ready  | rx_byte[7:0], buffer_end
//  res      | out | valid/ready  | kind, payload_byte, payload_index, status, frame_done
//  cfg      | in  | cfg_wr_en    | cfg_wr_data[2:0] -> ident_length
//
//  One byte per cycle sustained while res is not stalled; a request passes through
//  the input register and then the result register around the decode on its way to res.
//  arst_n clears the frame state, both valid flags and sets ident_length to 4.
//  A stall on res holds the result register; rx keeps accepting while the input
//  register holds a byte that yields no result or can move on.
// ----------------------------------------------------------------------------
module meter_link_frame_checker (
	input  logic       clk,
	input  logic       arst_n,
	mlfc_rx_if.sink    rx,
	mlfc_res_if.source res,
	input  logic       cfg_wr_en,
	input  logic [2:0] cfg_wr_data
);

	logic              valid_s1;
	mlfc_pkg::item_t   item_s1;
	logic              out_valid_q;
	mlfc_pkg::result_t out_q;
	logic [2:0]        ident_length_q;
	mlfc_pkg::result_t result;
	logic              advance;

	assign advance  = valid_s1 && (!result.has || !out_valid_q || res.ready);
	assign rx.ready = !valid_s1 || advance;

	mlfc_frame u_frame (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item_s1),
		.advance      (advance),
		.ident_length (ident_length_q),
		.result       (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ident_length_q <= mlfc_pkg::IDENT_LENGTH_RST;
		end else if (cfg_wr_en) begin
			ident_length_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			item_s1.rx_byte    <= rx.rx_byte;
			item_s1.buffer_end <= rx.buffer_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && result.has) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && result.has) begin
			out_q <= result;
		end
	end

	assign res.valid         = out_valid_q;
	assign res.kind          = out_q.kind;
	assign res.payload_byte  = out_q.payload_byte;
	assign res.payload_index = out_q.payload_index;
	assign res.status        = out_q.status;
	assign res.frame_done    = out_q.frame_done;

endmodule

// ===== rtl/mlfc_checker.sv =====
// ----------------------------------------------------------------------------
// mlfc_checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module mlfc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       res_valid,
	input logic       res_ready,
	input logic [1:0] res_kind,
	input logic [7:0] res_payload_byte,
	input logic [7:0] res_payload_index,
	input logic [2:0] res_status,
	input logic       res_frame_done
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_kind)
		&& $stable(res_payload_byte) && $stable(res_payload_index)
		&& $stable(res_status) && $stable(res_frame_done))
		else $error("result changed while stalled");

	a_status_shape: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_kind == mlfc_pkg::KIND_STATUS |->
		res_frame_done && res_payload_byte == 8'd0 && res_payload_index == 8'd0
		&& res_status != 3'd7)
		else $error("malformed status result");

	a_payload_shape: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_kind != mlfc_pkg::KIND_STATUS |->
		!res_frame_done && res_status == mlfc_pkg::ST_OK
		&& (res_kind == mlfc_pkg::KIND_IDENT || res_kind == mlfc_pkg::KIND_VALUE))
		else $error("malformed payload result");

	a_ident_first: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_kind == mlfc_pkg::KIND_IDENT |-> res_payload_index < 8'd7)
		else $error("identifier byte beyond identifier field");

endmodule

bind meter_link_frame_checker mlfc_checker u_mlfc_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.res_valid         (res.valid),
	.res_ready         (res.ready),
	.res_kind          (res.kind),
	.res_payload_byte  (res.payload_byte),
	.res_payload_index (res.payload_index),
	.res_status        (res.status),
	.res_frame_done    (res.frame_done)
);
